/* src/slti_pkg.sv */
// Shared types and constants for the smoothed level to interval block.
// No dependencies; the design files refer to this package by scoped names, the testbench imports it.
`default_nettype none

package slti_pkg;

	localparam int LEVEL_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int Q12_W      = 13;
	localparam int WLEN_W     = 7;
	localparam int SPAN_W     = 16;
	localparam int IVL_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_BITS  = 12;

	localparam logic [Q12_W-1:0] ONE_Q12 = 13'd4096;

	localparam logic [CFG_IDX_W-1:0] REG_USE_MANUAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MANUAL_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_FRACTION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_SPAN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_BASE = 3'd6;

	typedef struct packed {
		logic                      use_manual;
		logic signed [LEVEL_W-1:0] manual_level;
		logic [GAIN_W-1:0]         gain;
		logic [WLEN_W-1:0]         window_len;
		logic [Q12_W-1:0]          keep;
		logic [SPAN_W-1:0]         span;
		logic [SPAN_W-1:0]         base;
		logic                      window_clear;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic update;
		logic div_step;
		logic limit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

/* src/slti_cfg.sv */
// Configuration register file for the smoothed level to interval block.
// Depends on slti_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module slti_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [slti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [slti_pkg::CFG_DATA_W-1:0]    cfg_data,
	output slti_pkg::cfg_t                          cfg
);

	logic                               use_manual_q;
	logic signed [slti_pkg::LEVEL_W-1:0] manual_level_q;
	logic [slti_pkg::GAIN_W-1:0]        gain_q;
	logic [slti_pkg::WLEN_W-1:0]        window_len_q;
	logic [slti_pkg::Q12_W-1:0]         keep_q;
	logic [slti_pkg::SPAN_W-1:0]        span_q;
	logic [slti_pkg::SPAN_W-1:0]        base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_manual_q   <= 1'b1;
			manual_level_q <= 16'sd1229;
			gain_q         <= 16'd256;
			window_len_q   <= 7'd8;
			keep_q         <= 13'd3686;
			span_q         <= 16'd1000;
			base_q         <= 16'd300;
		end else if (cfg_write) begin
			unique case (cfg_index)
				slti_pkg::REG_USE_MANUAL:    use_manual_q   <= cfg_data[0];
				slti_pkg::REG_MANUAL_LEVEL:  manual_level_q <= $signed(cfg_data);
				slti_pkg::REG_GAIN:          gain_q         <= cfg_data;
				slti_pkg::REG_WINDOW_LEN:    window_len_q   <= cfg_data[slti_pkg::WLEN_W-1:0];
				slti_pkg::REG_KEEP_FRACTION: keep_q         <= cfg_data[slti_pkg::Q12_W-1:0];
				slti_pkg::REG_INTERVAL_SPAN: span_q         <= cfg_data;
				slti_pkg::REG_INTERVAL_BASE: base_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// The keep fraction saturates at 1.0; a window write empties the history.
	always_comb begin
		cfg.use_manual   = use_manual_q;
		cfg.manual_level = manual_level_q;
		cfg.gain         = gain_q;
		cfg.window_len   = window_len_q;
		cfg.keep         = (keep_q > slti_pkg::ONE_Q12) ? slti_pkg::ONE_Q12 : keep_q;
		cfg.span         = span_q;
		cfg.base         = base_q;
		cfg.window_clear = cfg_write && (cfg_index == slti_pkg::REG_WINDOW_LEN);
	end

endmodule

`default_nettype wire

/* src/slti_ctrl.sv */
// Sequencing state machine for the smoothed level to interval block.
// Depends on slti_pkg for the command and status bundles.
`default_nettype none

module slti_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire slti_pkg::status_t status,
	output slti_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_LIM  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd.capture  = accept;
		cmd.mul      = (state_q == S_MUL);
		cmd.update   = (state_q == S_UPD);
		cmd.div_step = (state_q == S_DIV);
		cmd.limit    = (state_q == S_LIM);
		cmd.load_out = (state_q == S_OUT) && status.out_free;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_next = S_MUL;
			S_MUL:  state_next = S_UPD;
			S_UPD:  state_next = S_DIV;
			S_DIV:  if (status.div_done) state_next = S_LIM;
			S_LIM:  state_next = S_OUT;
			S_OUT:  if (status.out_free) state_next = S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_MUL)
		else $error("accepted item did not start the multiply step");

	a_load_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == S_IDLE)
		else $error("result load did not return the sequencer to idle");

	a_state_known: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= S_OUT)
		else $error("sequencer left the set of defined states");

endmodule

`default_nettype wire

/* src/slti_dp.sv */
// Datapath: level scaling, history memory, running sum, restoring radix-2 divider,
// decay limit, interval and the output register. Depends on slti_pkg.
`default_nettype none

module slti_dp #(
	parameter int MAX_WINDOW = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire slti_pkg::cfg_t                     cfg,
	input  wire slti_pkg::cmd_t                     cmd,
	output slti_pkg::status_t                       status,
	input  wire logic signed [slti_pkg::LEVEL_W-1:0] level_sample,
	input  wire logic                               out_stall,
	output logic                                    out_valid,
	output logic [slti_pkg::Q12_W-1:0]              clamped_level,
	output logic [slti_pkg::Q12_W-1:0]              smoothed_level,
	output logic [slti_pkg::IVL_W-1:0]              beat_interval
);

	localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W  = slti_pkg::Q12_W + WIN_W;
	localparam int DC_W   = $clog2(SUM_W);
	localparam int PROD_W = slti_pkg::LEVEL_W + slti_pkg::GAIN_W + 1;
	localparam int FPR_W  = 2 * slti_pkg::Q12_W;
	localparam int SPR_W  = slti_pkg::Q12_W + slti_pkg::SPAN_W;

	logic signed [slti_pkg::LEVEL_W-1:0] level_q;
	logic [slti_pkg::Q12_W-1:0]          clamped_q;
	logic [slti_pkg::Q12_W-1:0]          old_q;
	logic [SUM_W-1:0]                    sum_q;
	logic [WIN_W-1:0]                    count_q;
	logic [IDX_W-1:0]                    slot_q;
	logic [slti_pkg::Q12_W-1:0]          prev_q;
	logic [SUM_W-1:0]                    dq_q;
	logic [WIN_W-1:0]                    rem_q;
	logic [DC_W-1:0]                     dcnt_q;
	logic                                out_valid_q;
	logic [slti_pkg::Q12_W-1:0]          clamped_out_q;
	logic [slti_pkg::Q12_W-1:0]          smoothed_out_q;
	logic [slti_pkg::IVL_W-1:0]          interval_out_q;

	logic [slti_pkg::Q12_W-1:0] hist_mem [MAX_WINDOW];

	logic [WIN_W-1:0]                win;
	logic signed [PROD_W-1:0]        prod;
	logic [PROD_W-9:0]               prod_shr;
	logic [slti_pkg::Q12_W-1:0]      clamp_next;
	logic                            full;
	logic [SUM_W-1:0]                sum_next;
	logic [WIN_W-1:0]                count_next;
	logic [WIN_W:0]                  slot_inc;
	logic [IDX_W-1:0]                slot_next;
	logic [WIN_W:0]                  rem_sh;
	logic [WIN_W:0]                  rem_sub;
	logic                            q_bit;
	logic [FPR_W-1:0]                floor_prod;
	logic [FPR_W-slti_pkg::FRAC_BITS-1:0] floor_val;
	logic [slti_pkg::Q12_W-1:0]      avg_next;
	logic [SPR_W-1:0]                span_prod;
	logic [slti_pkg::IVL_W-1:0]      interval_next;

	// Effective window: zero counts as one, long windows saturate.
	always_comb begin
		if (cfg.window_len == '0) begin
			win = WIN_W'(1);
		end else if (int'(cfg.window_len) > MAX_WINDOW) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = WIN_W'(cfg.window_len);
		end
	end

	// Scaling: exact product, negative or zero gives level zero, then saturate at 1.0.
	assign prod     = level_q * $signed({1'b0, cfg.gain});
	assign prod_shr = prod[PROD_W-1:8];
	always_comb begin
		if (prod <= 0) begin
			clamp_next = '0;
		end else if (prod_shr > (PROD_W-8)'(slti_pkg::ONE_Q12)) begin
			clamp_next = slti_pkg::ONE_Q12;
		end else begin
			clamp_next = prod_shr[slti_pkg::Q12_W-1:0];
		end
	end

	// Window update; the oldest level leaves once the window is full.
	assign full       = (count_q >= win);
	assign sum_next   = sum_q - (full ? SUM_W'(old_q) : SUM_W'(0)) + SUM_W'(clamped_q);
	assign count_next = full ? win : count_q + 1'b1;
	assign slot_inc   = (WIN_W+1)'(slot_q) + 1'b1;
	assign slot_next  = (slot_inc >= (WIN_W+1)'(win)) ? '0 : slot_q + 1'b1;

	// One restoring division step per cycle; dq_q shifts the dividend out
	// and the quotient in.
	assign rem_sh  = {rem_q, dq_q[SUM_W-1]};
	assign q_bit   = (rem_sh >= {1'b0, count_q});
	assign rem_sub = rem_sh - {1'b0, count_q};

	assign floor_prod = prev_q * cfg.keep;
	assign floor_val  = floor_prod[FPR_W-1:slti_pkg::FRAC_BITS];
	assign avg_next   = (dq_q < SUM_W'(floor_val)) ?
		floor_val[slti_pkg::Q12_W-1:0] : dq_q[slti_pkg::Q12_W-1:0];

	assign span_prod     = (slti_pkg::ONE_Q12 - prev_q) * cfg.span;
	assign interval_next = slti_pkg::IVL_W'(cfg.base) +
		span_prod[SPR_W-1:slti_pkg::FRAC_BITS];

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hist_mem[slot_q] <= clamped_q;
		end
		if (cmd.mul) begin
			old_q <= hist_mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			level_q <= cfg.use_manual ? cfg.manual_level : level_sample;
		end
		if (cmd.mul) begin
			clamped_q <= clamp_next;
		end
		if (cmd.update) begin
			dq_q   <= sum_next;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dq_q   <= {dq_q[SUM_W-2:0], q_bit};
			rem_q  <= q_bit ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.load_out) begin
			clamped_out_q  <= clamped_q;
			smoothed_out_q <= prev_q;
			interval_out_q <= interval_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			slot_q  <= '0;
		end else if (cfg.window_clear) begin
			sum_q   <= '0;
			count_q <= '0;
			slot_q  <= '0;
		end else if (cmd.update) begin
			sum_q   <= sum_next;
			count_q <= count_next;
			slot_q  <= slot_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.limit) begin
			prev_q <= avg_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.div_done = (dcnt_q == DC_W'(SUM_W - 1));
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign clamped_level  = clamped_out_q;
	assign smoothed_level = smoothed_out_q;
	assign beat_interval  = interval_out_q;

	a_divisor_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (count_q != '0) && (count_q <= win))
		else $error("divider running with an empty or oversized count");

	a_quotient_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.limit |-> dq_q <= SUM_W'(slti_pkg::ONE_Q12))
		else $error("window average exceeds full scale");

	a_output_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (clamped_out_q <= slti_pkg::ONE_Q12) &&
			(smoothed_out_q <= slti_pkg::ONE_Q12))
		else $error("output level exceeds full scale");

endmodule

`default_nettype wire

/* src/smoothed_level_to_interval.sv */
// Top level of the smoothed level to interval block.
// Depends on slti_pkg, slti_cfg, slti_ctrl and slti_dp.
`default_nettype none

//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  level_sample (s16, Q4.12)
//  output    out        out_valid/out_stall  clamped_level, smoothed_level (u13),
//                                            beat_interval (u17)
//  config    in         cfg_write            cfg_index (3), cfg_data (16)
//
// The block takes one item at a time and keeps in_stall high from acceptance until the
// item's result is loaded into the output register; the one-bit-per-cycle divider that
// forms the window average sits between the window update and the decay limit.
// Reset is asynchronous and active low; it loads the register defaults and
// empties the window. The history memory needs no clearing pass.
// The result sits in an output register; a stalled result holds the block
// at its final step only once the next result is ready to load.

module smoothed_level_to_interval #(
	parameter int MAX_WINDOW = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [slti_pkg::LEVEL_W-1:0] level_sample,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [slti_pkg::Q12_W-1:0]               clamped_level,
	output logic [slti_pkg::Q12_W-1:0]               smoothed_level,
	output logic [slti_pkg::IVL_W-1:0]               beat_interval,
	input  wire logic                                cfg_write,
	input  wire logic [slti_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [slti_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// Register values as the datapath sees them, with saturation applied.
	slti_pkg::cfg_t    cfg;
	// Step commands from the sequencer and the datapath's replies.
	slti_pkg::cmd_t    cmd;
	slti_pkg::status_t status;

	slti_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The sequencer walks one item through capture, scaling, the window
	// update, the division, the decay limit and the output load.
	slti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	slti_dp #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.level_sample   (level_sample),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.clamped_level  (clamped_level),
		.smoothed_level (smoothed_level),
		.beat_interval  (beat_interval)
	);

endmodule

`default_nettype wire

/* verif/tb_smoothed_level_to_interval.sv */
// Self-checking testbench for smoothed_level_to_interval: a directed table, then random register
// phases with random levels, both channels idling at random. Depends on slti_pkg and the block.
// Expected results come from a predictor inside this file that mirrors the block's arithmetic.

module tb_smoothed_level_to_interval;
	import slti_pkg::*;

	localparam int MAX_WINDOW = 64;
	localparam int unsigned FULL_SCALE = 4096;
	// Index 7 is past the end of the register list, so the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	// After the last result, wait SETTLE_CYCLES more before a register write or the final verdict.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_LEVELS = 1800;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [Q12_W-1:0] clamped;
		logic [Q12_W-1:0] smoothed;
		logic [IVL_W-1:0] interval;
	} beat_t;

	typedef struct {
		logic                      use_manual;
		logic signed [LEVEL_W-1:0] manual_level;
		logic [GAIN_W-1:0]         gain;
		logic [WLEN_W-1:0]         window_len;
		logic [Q12_W-1:0]          keep;
		logic [SPAN_W-1:0]         span;
		logic [SPAN_W-1:0]         base;
	} shadow_regs_t;

	// A row of the directed table is a register write, a level checked against the
	// predictor, or a level whose result is typed in by hand.
	typedef enum logic [1:0] {ROW_WRITE, ROW_LEVEL, ROW_KNOWN} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_DATA_W-1:0]     data;
		logic signed [LEVEL_W-1:0] level;
		beat_t                     want;
	} plan_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic signed [LEVEL_W-1:0] level_sample;
	logic                      out_valid;
	logic                      out_stall;
	logic [Q12_W-1:0]          clamped_level;
	logic [Q12_W-1:0]          smoothed_level;
	logic [IVL_W-1:0]          beat_interval;
	logic                      cfg_write;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	// Predictor state: a copy of the registers and of the averaging window.
	shadow_regs_t     shadow;
	logic [Q12_W-1:0] level_ring [MAX_WINDOW];
	int unsigned      ring_sum;
	int unsigned      ring_count;
	int unsigned      ring_slot;
	int unsigned      last_smoothed;
	int               level_target;

	beat_t     expected_beats [$];
	plan_row_t directed_plan [$];

	int failures;
	int beats_checked;
	int levels_sent;
	int random_levels;
	int reg_writes;
	int phases;
	int cycle_count;

	smoothed_level_to_interval #(
		.MAX_WINDOW(MAX_WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.level_sample(level_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.clamped_level(clamped_level),
		.smoothed_level(smoothed_level),
		.beat_interval(beat_interval),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is cut off if it ever takes far longer than the slowest legal run would.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, expected_beats.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Register defaults after reset, and an empty window. The previous average starts at zero.
	function automatic void reset_model();
		shadow.use_manual   = 1'b1;
		shadow.manual_level = 16'sd1229;
		shadow.gain         = 16'd256;
		shadow.window_len   = 7'd8;
		shadow.keep         = 13'd3686;
		shadow.span         = 16'd1000;
		shadow.base         = 16'd300;
		ring_sum      = 0;
		ring_count    = 0;
		ring_slot     = 0;
		last_smoothed = 0;
	endfunction

	// Each register keeps only as many low bits of the write data as it is wide. A write to
	// the window length also empties the window but leaves the previous average alone.
	function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_USE_MANUAL:    shadow.use_manual = data[0];
			REG_MANUAL_LEVEL:  shadow.manual_level = data;
			REG_GAIN:          shadow.gain = data;
			REG_WINDOW_LEN: begin
				shadow.window_len = data[WLEN_W-1:0];
				ring_sum   = 0;
				ring_count = 0;
				ring_slot  = 0;
			end
			REG_KEEP_FRACTION: shadow.keep = data[Q12_W-1:0];
			REG_INTERVAL_SPAN: shadow.span = data;
			REG_INTERVAL_BASE: shadow.base = data;
			default: ;
		endcase
	endfunction

	// Works out the result of one accepted level and advances the predictor's window.
	function automatic beat_t next_beat(input logic signed [LEVEL_W-1:0] sample);
		longint      product;
		int unsigned win;
		int unsigned keep;
		int unsigned clamped;
		int unsigned avg;
		int unsigned floor_lvl;
		beat_t       b;

		// The product of level and gain is exact; a negative or zero product gives level zero,
		// otherwise the Q8.8 gain is shifted out and the level saturates at 1.0.
		product = shadow.use_manual ? longint'(shadow.manual_level) : longint'(sample);
		product = product * longint'(shadow.gain);
		if (product <= 0)
			clamped = 0;
		else if ((product >>> 8) > longint'(FULL_SCALE))
			clamped = FULL_SCALE;
		else
			clamped = 32'(product >>> 8);

		// A window length of zero acts as one, and anything past the memory depth as the depth.
		if (shadow.window_len == 0)
			win = 1;
		else if (shadow.window_len > MAX_WINDOW)
			win = MAX_WINDOW;
		else
			win = shadow.window_len;
		keep = (shadow.keep > FULL_SCALE) ? FULL_SCALE : shadow.keep;

		// With a full window the oldest level leaves the sum before the new one enters.
		if (ring_slot >= win)
			ring_slot = 0;
		if (ring_count >= win) begin
			ring_sum   = ring_sum - level_ring[ring_slot];
			ring_count = win;
		end else begin
			ring_count = ring_count + 1;
		end
		level_ring[ring_slot] = Q12_W'(clamped);
		ring_sum  = ring_sum + clamped;
		ring_slot = (ring_slot + 1 >= win) ? 0 : ring_slot + 1;

		// The average may sink by at most one minus the keep fraction per item.
		avg = ring_sum / ring_count;
		floor_lvl = (last_smoothed * keep) >> FRAC_BITS;
		if (avg < floor_lvl)
			avg = floor_lvl;
		last_smoothed = avg;

		b.clamped  = Q12_W'(clamped);
		b.smoothed = Q12_W'(avg);
		b.interval = IVL_W'(shadow.base + (((FULL_SCALE - avg) * shadow.span) >> FRAC_BITS));
		return b;
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		return '{ROW_WRITE, idx, data, '0, '0};
	endfunction

	function automatic plan_row_t level_row(input logic signed [LEVEL_W-1:0] level);
		return '{ROW_LEVEL, '0, '0, level, '0};
	endfunction

	function automatic plan_row_t known_row(input logic signed [LEVEL_W-1:0] level,
			input int unsigned c, input int unsigned s, input int unsigned i);
		return '{ROW_KNOWN, '0, '0, level, '{Q12_W'(c), Q12_W'(s), IVL_W'(i)}};
	endfunction

	// Random register values lean toward the ends of each range and toward settings that
	// keep the level out of saturation, so the window and the decay floor both get exercised.
	function automatic logic [CFG_DATA_W-1:0] pick_reg_value(input logic [CFG_IDX_W-1:0] idx);
		logic [CFG_DATA_W-1:0] v;
		int r;

		v = CFG_DATA_W'($urandom);
		r = $urandom_range(0, 9);
		case (idx)
			REG_USE_MANUAL: v[0] = (r < 2);
			REG_GAIN: begin
				if (r == 0)
					v = '0;
				else if (r == 1)
					v = '1;
				else if (r < 8)
					v = CFG_DATA_W'($urandom_range(128, 1024));
			end
			REG_WINDOW_LEN: begin
				if (r < 5)
					v[WLEN_W-1:0] = WLEN_W'($urandom_range(1, 8));
				else if (r < 7)
					v[WLEN_W-1:0] = WLEN_W'($urandom_range(9, MAX_WINDOW));
				else if (r == 7)
					v[WLEN_W-1:0] = '0;
				else if (r == 8)
					v[WLEN_W-1:0] = WLEN_W'(MAX_WINDOW);
				else
					v[WLEN_W-1:0] = WLEN_W'($urandom_range(MAX_WINDOW + 1, 127));
			end
			REG_KEEP_FRACTION: begin
				if (r == 0)
					v[Q12_W-1:0] = '0;
				else if (r == 1)
					v[Q12_W-1:0] = Q12_W'(FULL_SCALE);
				else if (r == 2)
					v[Q12_W-1:0] = Q12_W'($urandom_range(FULL_SCALE + 1, 8191));
				else
					v[Q12_W-1:0] = Q12_W'($urandom_range(2048, FULL_SCALE - 1));
			end
			REG_INTERVAL_SPAN, REG_INTERVAL_BASE: begin
				if (r == 0)
					v = '0;
				else if (r == 1)
					v = '1;
			end
			default: ;
		endcase
		return v;
	endfunction

	// Most levels wander around a target that jumps now and then, which drives the average
	// up and down and lets the decay floor catch falls. The rest are extremes and noise.
	function automatic logic signed [LEVEL_W-1:0] draw_level();
		int r;

		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 4))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				3: return 16'sh1000;
				default: return 16'shFFFF;
			endcase
		end
		if (r < 25)
			return LEVEL_W'($urandom);
		if ($urandom_range(0, 9) == 0)
			level_target = int'($urandom_range(0, 6000)) - 500;
		return LEVEL_W'(level_target + int'($urandom_range(0, 400)) - 200);
	endfunction

	// Each write holds the enable for exactly one edge and then drops it again before the task returns.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		note_reg_write(idx, data);
		reg_writes++;
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one level and holds it until the block takes it. The valid stays high when the
	// next level follows at once; otherwise it drops for a random gap, now and then a long one.
	task automatic send_level(input logic signed [LEVEL_W-1:0] sample, input logic typed,
			input beat_t typed_beat);
		beat_t predicted;
		int    r;
		int    gap;

		in_valid     <= 1'b1;
		level_sample <= sample;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = next_beat(sample);
		expected_beats.insert(expected_beats.size(), typed ? typed_beat : predicted);
		levels_sent++;
		r = $urandom_range(0, 99);
		if (r < 60)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(15, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits for every outstanding result, then lets the block settle.
	// Register writes only happen after this, so the block is idle when they land.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic tune_registers();
		logic [CFG_IDX_W-1:0] order [8];

		order = '{REG_USE_MANUAL, REG_MANUAL_LEVEL, REG_GAIN, REG_WINDOW_LEN,
			REG_KEEP_FRACTION, REG_INTERVAL_SPAN, REG_INTERVAL_BASE, REG_UNUSED};
		foreach (order[k]) begin
			if ($urandom_range(0, 1) == 1)
				write_reg(order[k], pick_reg_value(order[k]));
		end
	endtask

	// The receiver alternates stretches with no stall, stretches of scattered short stalls
	// and the occasional long stall, so stalls fall on every step of the block's work.
	initial begin : receiver_stalls
		int r;

		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 200)) @(posedge clk);
			end else if (r < 90) begin
				repeat ($urandom_range(1, 30)) begin
					out_stall <= ($urandom_range(0, 2) == 0);
					@(posedge clk);
				end
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(20, 40)) @(posedge clk);
			end
		end
	end

	// Every result taken from the block is compared with the oldest expectation, field by field.
	always @(posedge clk) begin : result_watch
		beat_t got;
		beat_t want;

		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {clamped_level, smoothed_level, beat_interval};
			if (expected_beats.size() == 0) begin
				failures++;
				$display("%0t: result with none expected: clamped %0d smoothed %0d interval %0d",
					$time, got.clamped, got.smoothed, got.interval);
			end else begin
				want = expected_beats.pop_front();
				beats_checked++;
				if (got.clamped !== want.clamped) begin
					failures++;
					$display("%0t: clamped_level expected %0d actual %0d", $time,
						want.clamped, got.clamped);
				end
				if (got.smoothed !== want.smoothed) begin
					failures++;
					$display("%0t: smoothed_level expected %0d actual %0d", $time,
						want.smoothed, got.smoothed);
				end
				if (got.interval !== want.interval) begin
					failures++;
					$display("%0t: beat_interval expected %0d actual %0d", $time,
						want.interval, got.interval);
				end
			end
		end
	end

	initial begin : stimulus
		int directed_levels;
		int phase_len;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		level_sample <= '0;
		cfg_write    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		failures      = 0;
		beats_checked = 0;
		levels_sent   = 0;
		random_levels = 0;
		reg_writes    = 0;
		phases        = 0;
		cycle_count   = 0;
		level_target  = 1024;
		reset_model();

		// Typed-in results: the defaults after reset, saturation both ways, zero and full gain,
		// the widest interval, a keep fraction past 1.0 that pins the average, and a window
		// length of zero that acts as one. The remaining rows lean on the predictor: window
		// length past the memory depth, the ignored index, manual mode at both extremes and a
		// short window that wraps and drops its oldest level.
		directed_plan = '{
			known_row(16'sh8000, 1229, 1229, 999),
			known_row(16'sh7FFF, 1229, 1229, 999),
			reg_row(REG_USE_MANUAL, 16'h0000),
			reg_row(REG_WINDOW_LEN, 16'h0001),
			reg_row(REG_KEEP_FRACTION, 16'h0000),
			known_row(16'sh7FFF, 4096, 4096, 300),
			known_row(16'sh8000, 0, 0, 1300),
			reg_row(REG_INTERVAL_SPAN, 16'hFFFF),
			reg_row(REG_INTERVAL_BASE, 16'hFFFF),
			known_row(16'sh0000, 0, 0, 131070),
			known_row(16'sh1000, 4096, 4096, 65535),
			reg_row(REG_GAIN, 16'h0000),
			known_row(16'sh7FFF, 0, 0, 131070),
			reg_row(REG_GAIN, 16'hFFFF),
			level_row(16'sh0001),
			known_row(16'shFFFF, 0, 0, 131070),
			reg_row(REG_KEEP_FRACTION, 16'h1FFF),
			known_row(16'sh4000, 4096, 4096, 65535),
			known_row(16'sh0000, 0, 4096, 65535),
			reg_row(REG_WINDOW_LEN, 16'h0000),
			reg_row(REG_KEEP_FRACTION, 16'h0000),
			reg_row(REG_GAIN, 16'h0100),
			reg_row(REG_INTERVAL_SPAN, 16'h0000),
			reg_row(REG_INTERVAL_BASE, 16'h0000),
			known_row(16'sh0800, 2048, 2048, 0),
			known_row(16'sh03E8, 1000, 1000, 0),
			reg_row(REG_WINDOW_LEN, 16'hFFFF),
			reg_row(REG_KEEP_FRACTION, 16'h0E66),
			reg_row(REG_INTERVAL_SPAN, 16'h03E8),
			reg_row(REG_INTERVAL_BASE, 16'h012C),
			level_row(16'sh0C00),
			level_row(16'sh0400),
			reg_row(REG_UNUSED, 16'hFFFF),
			level_row(16'sh0200),
			reg_row(REG_USE_MANUAL, 16'h0001),
			reg_row(REG_MANUAL_LEVEL, 16'h8000),
			level_row(16'sh1000),
			reg_row(REG_MANUAL_LEVEL, 16'h7FFF),
			level_row(16'sh0000),
			reg_row(REG_WINDOW_LEN, 16'h0002),
			reg_row(REG_USE_MANUAL, 16'h0000),
			level_row(16'sh0300),
			level_row(16'sh0900),
			level_row(16'sh0F00)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[n]) begin
			case (directed_plan[n].kind)
				ROW_WRITE: begin
					drain_pipeline();
					write_reg(directed_plan[n].idx, directed_plan[n].data);
				end
				ROW_LEVEL: send_level(directed_plan[n].level, 1'b0, '0);
				default: send_level(directed_plan[n].level, 1'b1, directed_plan[n].want);
			endcase
		end
		directed_levels = levels_sent;

		// Random phases: the sender stops until every result is back, a random subset of the
		// registers is rewritten, and a run of levels follows. Runs are 10 to 150 levels long, so
		// the largest window fills and wraps only in the longer runs.
		while (random_levels < RANDOM_LEVELS) begin
			drain_pipeline();
			tune_registers();
			phases++;
			phase_len = $urandom_range(10, 150);
			repeat (phase_len) begin
				send_level(draw_level(), 1'b0, '0);
				random_levels++;
			end
		end

		drain_pipeline();
		$display("Sent %0d levels (%0d from the directed table) over %0d random phases,",
			levels_sent, directed_levels, phases);
		$display("with %0d register writes; %0d results checked, %0d mismatches.",
			reg_writes, beats_checked, failures);
		if (failures == 0 && expected_beats.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
